### sv/tpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_pkg
// shared types and constants of the touch packet deframer
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam logic [7:0] HDR_FIRST    = 8'h55;
    localparam logic [7:0] HDR_SECOND   = 8'h54;

    // touch type code, bits 2:1 of the type byte
    localparam logic [1:0] KIND_PRESS   = 2'b01;
    localparam logic [1:0] KIND_RELEASE = 2'b10;

    localparam int COORD_W = 16;

    // one state per packet byte
    typedef enum logic [9:0] {
        ST_HUNT  = 10'b00_0000_0001,
        ST_HDR2  = 10'b00_0000_0010,
        ST_TYPE  = 10'b00_0000_0100,
        ST_XLO   = 10'b00_0000_1000,
        ST_XHI   = 10'b00_0001_0000,
        ST_YLO   = 10'b00_0010_0000,
        ST_YHI   = 10'b00_0100_0000,
        ST_PLO   = 10'b00_1000_0000,
        ST_PHI   = 10'b01_0000_0000,
        ST_FINAL = 10'b10_0000_0000
    } tpd_step_t;

    typedef struct packed {
        logic                 valid;
        logic                 kind;
        logic [COORD_W-1:0]   x_position;
        logic [COORD_W-1:0]   y_position;
        logic [COORD_W-1:0]   pressure;
    } tpd_result_t;

    typedef struct packed {
        tpd_step_t step;
    } tpd_status_t;

endpackage

### sv/touch_packet_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_packet_deframer_core
// decodes 10-byte touch controller packets into press / release events
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | transaction
//  s_axis   | in  | tdata[7:0] rx_byte                       | one received byte
//  m_axis   | out | tdata x/y/pressure, tuser touch_kind     | one touch event
//
//  one byte is taken per cycle, back to back, while s_tready is high
//  an event appears on m_axis in the cycle after the final packet byte is taken
//  reset puts the parser into header hunting with no event pending
//  s_tready drops only while an event is held and m_tready is low
// ----------------------------------------------------------------------------
module touch_packet_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] x_position, [31:16] y_position, [47:32] pressure
    output logic [0:0]  m_tuser     // [0] touch_kind (0 press, 1 release)
);

    tpd_pkg::tpd_result_t par_result;
    tpd_pkg::tpd_status_t par_status;

    logic        in_accept;
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg;
    logic        out_kind_reg;

    // output register parts the two sides; input stalls only on a held event that m_tready does not take
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    tpd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (in_accept),
        .byte_data   (s_tdata),
        .result      (par_result),
        .status      (par_status)
    );

    // a new event replaces the one being taken in the same cycle
    always_comb
    begin
        if (par_result.valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (par_result.valid)
        begin
            out_data_reg <= {par_result.pressure, par_result.y_position,
                             par_result.x_position};
            out_kind_reg <= par_result.kind;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_kind_reg;

`ifndef SYNTH
    // parser state stays one-hot
    a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(par_status.step))
        else $error("parser step not one-hot");

    // the trailing byte always returns the parser to hunting
    a_final_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && par_status.step == tpd_pkg::ST_FINAL)
        |=> (par_status.step == tpd_pkg::ST_HUNT))
        else $error("parser did not return to hunting after packet end");

    // events come only from an accepted trailing byte
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        par_result.valid |-> (in_accept && par_status.step == tpd_pkg::ST_FINAL))
        else $error("event raised outside packet end");

    // a freshly loaded event is presented on the next cycle
    a_event_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        par_result.valid |=> m_tvalid)
        else $error("decoded event not presented");
`endif

endmodule

### sv/tpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpd_parser
// byte-wise packet parser: header match, type, coordinate and pressure capture
// ----------------------------------------------------------------------------
module tpd_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_accept,
    input  logic [7:0]           byte_data,
    output tpd_pkg::tpd_result_t result,
    output tpd_pkg::tpd_status_t status
);

    tpd_pkg::tpd_step_t                 step_reg, step_next;
    logic [1:0]                         kind_reg, kind_next;
    logic [tpd_pkg::COORD_W-1:0]        x_reg, x_next;
    logic [tpd_pkg::COORD_W-1:0]        y_reg, y_next;
    logic [tpd_pkg::COORD_W-1:0]        p_reg, p_next;

    always_comb
    begin
        step_next = step_reg;
        kind_next = kind_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        p_next    = p_reg;
        result    = '0;
        case (step_reg)
            tpd_pkg::ST_HDR2:
            begin
                step_next = (byte_data == tpd_pkg::HDR_SECOND) ? tpd_pkg::ST_TYPE
                                                                : tpd_pkg::ST_HUNT;
            end
            tpd_pkg::ST_TYPE:
            begin
                kind_next = byte_data[2:1];
                step_next = tpd_pkg::ST_XLO;
            end
            tpd_pkg::ST_XLO:
            begin
                x_next    = {8'h00, byte_data};
                step_next = tpd_pkg::ST_XHI;
            end
            tpd_pkg::ST_XHI:
            begin
                x_next    = {byte_data, x_reg[7:0]};
                step_next = tpd_pkg::ST_YLO;
            end
            tpd_pkg::ST_YLO:
            begin
                y_next    = {8'h00, byte_data};
                step_next = tpd_pkg::ST_YHI;
            end
            tpd_pkg::ST_YHI:
            begin
                y_next    = {byte_data, y_reg[7:0]};
                step_next = tpd_pkg::ST_PLO;
            end
            tpd_pkg::ST_PLO:
            begin
                p_next    = {8'h00, byte_data};
                step_next = tpd_pkg::ST_PHI;
            end
            tpd_pkg::ST_PHI:
            begin
                p_next    = {byte_data, p_reg[7:0]};
                step_next = tpd_pkg::ST_FINAL;
            end
            tpd_pkg::ST_FINAL:
            begin
                // trailing byte ignored, unknown types dropped
                result.valid      = byte_accept && ((kind_reg == tpd_pkg::KIND_PRESS) ||
                                                    (kind_reg == tpd_pkg::KIND_RELEASE));
                result.kind       = (kind_reg == tpd_pkg::KIND_RELEASE);
                result.x_position = x_reg;
                result.y_position = y_reg;
                result.pressure   = p_reg;
                step_next         = tpd_pkg::ST_HUNT;
            end
            default:
            begin
                step_next = (byte_data == tpd_pkg::HDR_FIRST) ? tpd_pkg::ST_HDR2
                                                               : tpd_pkg::ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tpd_pkg::ST_HUNT;
            kind_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            p_reg    <= '0;
        end
        else if (byte_accept)
        begin
            step_reg <= step_next;
            kind_reg <= kind_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            p_reg    <= p_next;
        end
    end

    assign status.step = step_reg;

endmodule
